[rtl/wta_pkg.sv]
// shared types, constants and helper functions of the windowed threshold alarm
package wta_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int TIME_WIDTH   = 32;
  localparam int VAL_W        = 16;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = VAL_W + $clog2(WINDOW_DEPTH) + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGG_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd6;

  localparam logic [1:0] AGG_AVG = 2'd0;
  localparam logic [1:0] AGG_MAX = 2'd1;
  localparam logic [1:0] AGG_MIN = 2'd2;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_ABOVE  = 2'd1;
  localparam logic [1:0] EV_BELOW  = 2'd2;
  localparam logic [1:0] EV_NORMAL = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_DIV,
    S_COMPACT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]   t;
    logic signed [VAL_W-1:0] smp;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  // position i of the window, counted from the oldest entry
  function automatic logic [IDX_W-1:0] slot_f(logic [IDX_W-1:0] head, logic [CNT_W-1:0] i);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(i);
    if (s >= (CNT_W+1)'(WINDOW_DEPTH)) s = s - (CNT_W+1)'(WINDOW_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  // entry older than the window; a time ahead of now never ages
  function automatic logic aged_f(logic [TIME_WIDTH-1:0] now, logic [TIME_WIDTH-1:0] t,
                                  logic [15:0] ws);
    logic [TIME_WIDTH-1:0] d;
    d = now - t;
    return (now >= t) && (d >= TIME_WIDTH'(ws));
  endfunction

endpackage

[rtl/windowed_threshold_alarm.sv]
// windowed threshold alarm top level: control sequencer, registers and output stage
// a disabled request goes straight to the output stage; an enabled one is appended, then
//   all entries held after the append (1 to 64) are scanned at one read per cycle
// no aged entry: the sample is checked; aged: max, min or divided average, then compaction
// throughput: one request at a time, next request taken once the result is registered
// reset clears registers, window count, head, alarm state and last report time;
//   the window memory is not cleared, only entries below the count are ever read
module windowed_threshold_alarm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [47:0]                     in_tdata,   // now_seconds[31:0], sample[47:32]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // report[0], checked_value[16:1], healthy[17], window_overflow[18], zero[23:19]
  output logic [23:0]                     out_tdata,
  output logic [1:0]                      out_tuser,  // event_kind[1:0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wta_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wta_pkg::*;

  // configuration
  logic              enable_r;
  logic [1:0]        agg_mode_r;
  logic [1:0]        thr_mode_r;
  logic signed [15:0] max_limit_r;
  logic signed [15:0] min_limit_r;
  logic [15:0]       window_r;
  logic [15:0]       repeat_r;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  alarm_r, alarm_nxt;
  logic [TIME_WIDTH-1:0] last_r, last_nxt;

  logic [TIME_WIDTH-1:0]   now_r, now_nxt;
  logic signed [VAL_W-1:0] smp_r, smp_nxt;
  logic                    dis_r, dis_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]        kept_r, kept_nxt;
  logic                    dvalid_r, dvalid_nxt;
  logic                    any_aged_r, any_aged_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [VAL_W-1:0] mx_r, mx_nxt, mn_r, mn_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  mem_wr_t wr;
  mem_rd_t rd;
  entry_t  rdata;
  logic    rd_aged;

  logic                    div_start;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_q;

  logic                  tmax, tmin, trig, rep_ok;
  logic [TIME_WIDTH-1:0] since;
  logic                  rep;
  logic [1:0]            kind;
  logic                  hlth;

  wta_window_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  wta_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum      (sum_r),
    .count    (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      agg_mode_r  <= AGG_AVG;
      thr_mode_r  <= 2'd0;
      max_limit_r <= '0;
      min_limit_r <= '0;
      window_r    <= '0;
      repeat_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:    enable_r    <= cfg_data[0];
        REG_AGG_MODE:  agg_mode_r  <= cfg_data[1:0];
        REG_THR_MODE:  thr_mode_r  <= cfg_data[1:0];
        REG_MAX_LIMIT: max_limit_r <= cfg_data;
        REG_MIN_LIMIT: min_limit_r <= cfg_data;
        REG_WINDOW:    window_r    <= cfg_data;
        REG_REPEAT:    repeat_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rd_aged = aged_f(now_r, rdata.t, window_r);

  // limit check and report decision on the checked value
  always_comb begin
    since  = now_r - last_r;
    tmax   = thr_mode_r[0] && (value_r > max_limit_r);
    tmin   = thr_mode_r[1] && (value_r < min_limit_r);
    trig   = tmax || tmin;
    rep_ok = (last_r == '0) || (repeat_r == '0) ||
             ((now_r >= last_r) && (since > TIME_WIDTH'(repeat_r)));
    rep    = 1'b0;
    kind   = EV_NONE;
    hlth   = 1'b1;
    if (trig) begin
      hlth = 1'b0;
      if (rep_ok) begin
        rep  = 1'b1;
        kind = tmin ? EV_BELOW : EV_ABOVE;
      end
    end else if (alarm_r) begin
      rep  = 1'b1;
      kind = EV_NORMAL;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    alarm_nxt     = alarm_r;
    last_nxt      = last_r;
    now_nxt       = now_r;
    smp_nxt       = smp_r;
    dis_nxt       = dis_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    kept_nxt      = kept_r;
    dvalid_nxt    = 1'b0;
    any_aged_nxt  = any_aged_r;
    sum_nxt       = sum_r;
    mx_nxt        = mx_r;
    mn_nxt        = mn_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    in_tready     = 1'b0;
    div_start     = 1'b0;
    wr            = '0;
    rd            = '0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          now_nxt = in_tdata[31:0];
          smp_nxt = in_tdata[47:32];
          dis_nxt = !enable_r;
          ovf_nxt = 1'b0;
          state_nxt = enable_r ? S_APPEND : S_OUT;
        end
      end
      S_APPEND: begin
        wr.en   = 1'b1;
        wr.data = '{t: now_r, smp: smp_r};
        if (count_r == CNT_W'(WINDOW_DEPTH)) begin
          // full: overwrite the oldest entry and move the head past it
          wr.addr  = head_r;
          head_nxt = (head_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;
          ovf_nxt  = 1'b1;
        end else begin
          wr.addr   = slot_f(head_r, count_r);
          count_nxt = count_r + 1'b1;
        end
        i_nxt        = '0;
        any_aged_nxt = 1'b0;
        sum_nxt      = '0;
        mx_nxt       = {1'b0, {(VAL_W-1){1'b1}}} ^ {VAL_W{1'b1}};
        mn_nxt       = {1'b0, {(VAL_W-1){1'b1}}};
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        if (i_r < count_r) begin
          rd.en      = 1'b1;
          rd.addr    = slot_f(head_r, i_r);
          i_nxt      = i_r + 1'b1;
          dvalid_nxt = 1'b1;
        end
        if (dvalid_r) begin
          if (rd_aged) any_aged_nxt = 1'b1;
          sum_nxt = sum_r + SUM_W'(rdata.smp);
          if (rdata.smp > mx_r) mx_nxt = rdata.smp;
          if (rdata.smp < mn_r) mn_nxt = rdata.smp;
        end
        if ((i_r == count_r) && !dvalid_r) begin
          i_nxt    = '0;
          kept_nxt = '0;
          if (!any_aged_r) begin
            value_nxt = smp_r;
            state_nxt = S_OUT;
          end else begin
            case (agg_mode_r)
              AGG_MAX: begin
                value_nxt = mx_r;
                state_nxt = S_COMPACT;
              end
              AGG_MIN: begin
                value_nxt = mn_r;
                state_nxt = S_COMPACT;
              end
              default: begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          value_nxt = div_q;
          state_nxt = S_COMPACT;
        end
      end
      S_COMPACT: begin
        // kept trails the read index, so a move never lands on an unread entry
        if (i_r < count_r) begin
          rd.en      = 1'b1;
          rd.addr    = slot_f(head_r, i_r);
          i_nxt      = i_r + 1'b1;
          dvalid_nxt = 1'b1;
        end
        if (dvalid_r && !rd_aged) begin
          wr.en    = 1'b1;
          wr.addr  = slot_f(head_r, kept_r);
          wr.data  = rdata;
          kept_nxt = kept_r + 1'b1;
        end
        if ((i_r == count_r) && !dvalid_r) begin
          count_nxt = kept_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (dis_r) begin
            out_data_nxt = {5'd0, 1'b0, 1'b1, {VAL_W{1'b0}}, 1'b0};
            out_user_nxt = EV_NONE;
          end else begin
            out_data_nxt = {5'd0, ovf_r, hlth, value_r, rep};
            out_user_nxt = kind;
            if (trig && rep_ok) begin
              last_nxt  = now_r;
              alarm_nxt = 1'b1;
            end else if (!trig && alarm_r) begin
              alarm_nxt = 1'b0;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      alarm_r     <= 1'b0;
      last_r      <= '0;
      dvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      alarm_r     <= alarm_nxt;
      last_r      <= last_nxt;
      dvalid_r    <= dvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    smp_r      <= smp_nxt;
    dis_r      <= dis_nxt;
    ovf_r      <= ovf_nxt;
    i_r        <= i_nxt;
    kept_r     <= kept_nxt;
    any_aged_r <= any_aged_nxt;
    sum_r      <= sum_nxt;
    mx_r       <= mx_nxt;
    mn_r       <= mn_nxt;
    value_r    <= value_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WINDOW_DEPTH))
    else $error("window count above depth");

  a_kind_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser != EV_NONE) == out_tdata[0]))
    else $error("event kind and report flag disagree");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPACT) |-> (kept_r <= i_r))
    else $error("compaction write index passed the read index");

endmodule

[rtl/wta_window_mem.sv]
// window store: sample and timestamp entries, one write and one registered read port
module wta_window_mem (
  input  logic             clk,
  input  wta_pkg::mem_wr_t wr,
  input  wta_pkg::mem_rd_t rd,
  output wta_pkg::entry_t  rdata
);
  import wta_pkg::*;

  entry_t mem [WINDOW_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/wta_divider.sv]
// serial restoring divider for the window average, one quotient bit per cycle
module wta_divider (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [wta_pkg::SUM_W-1:0]     sum,
  input  logic        [wta_pkg::CNT_W-1:0]     count,
  output logic                                 done,
  output logic signed [wta_pkg::VAL_W-1:0]     quotient
);
  import wta_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [CNT_W:0]    trial;
  logic [VAL_W:0]    mag;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, quo_r[SUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = sum[SUM_W-1];
      quo_nxt  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem_nxt  = '0;
      div_nxt  = count;
      step_nxt = STEP_W'(SUM_W);
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, div_r});
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign mag      = quo_r[VAL_W:0];
  assign quotient = neg_r ? VAL_W'(-mag) : VAL_W'(mag);
  assign done     = done_r;

endmodule

[tb/tb_windowed_threshold_alarm.sv]
// testbench for the windowed threshold alarm: directed and random samples checked against a predictor
`timescale 1ns / 100ps

module tb_windowed_threshold_alarm;
  import wta_pkg::*;

  typedef struct {
    logic [31:0]        now;
    logic signed [15:0] smp;
  } sample_req_t;

  typedef struct {
    logic               report;
    logic [1:0]         kind;
    logic signed [15:0] value;
    logic               healthy;
    logic               ovf;
  } alarm_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  windowed_threshold_alarm dut (.*);

  // predictor copy of the registers
  logic               c_en;
  logic [1:0]         c_agg;
  logic [1:0]         c_thr;
  logic signed [15:0] c_max;
  logic signed [15:0] c_min;
  logic [15:0]        c_win;
  logic [15:0]        c_rep;

  // predictor copy of the window and alarm state
  logic signed [15:0] win_smp [WINDOW_DEPTH];
  logic [31:0]        win_time [WINDOW_DEPTH];
  int                 win_head;
  int                 win_count;
  logic               alarm_on;
  logic [31:0]        last_report;

  sample_req_t pending_q[$];
  alarm_res_t  expected_q[$];
  logic        in_taken;
  int          send_pct, recv_pct;
  logic        pressure_armed;
  logic        hold_done;
  int          hold_cnt;
  int          errors, n_samples, n_reports, n_overflows;
  logic [31:0] t_cur;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_windowed_threshold_alarm: errors");
    $finish;
  end

  function automatic logic is_aged(logic [31:0] now, logic [31:0] t);
    return (now >= t) && ((now - t) >= {16'd0, c_win});
  endfunction

  function automatic alarm_res_t alarm_predict(logic [31:0] now, logic signed [15:0] s);
    alarm_res_t r;
    logic any_aged, tmax, tmin;
    longint sum;
    logic signed [15:0] mx, mn, v;
    int idx, kept, src, dst;
    r = '{1'b0, EV_NONE, 16'sd0, 1'b1, 1'b0};
    if (!c_en) return r;
    if (win_count >= WINDOW_DEPTH) begin
      win_smp[win_head] = s;
      win_time[win_head] = now;
      win_head = (win_head + 1) % WINDOW_DEPTH;
      r.ovf = 1'b1;
    end else begin
      idx = (win_head + win_count) % WINDOW_DEPTH;
      win_smp[idx] = s;
      win_time[idx] = now;
      win_count++;
    end
    r.value = s;
    any_aged = 1'b0;
    for (int i = 0; i < win_count; i++)
      if (is_aged(now, win_time[(win_head + i) % WINDOW_DEPTH])) any_aged = 1'b1;
    if (any_aged) begin
      sum = 0;
      mx = win_smp[win_head];
      mn = mx;
      for (int i = 0; i < win_count; i++) begin
        v = win_smp[(win_head + i) % WINDOW_DEPTH];
        sum += v;
        if (v > mx) mx = v;
        if (v < mn) mn = v;
      end
      if (c_agg == AGG_MAX) r.value = mx;
      else if (c_agg == AGG_MIN) r.value = mn;
      else r.value = 16'(sum / longint'(win_count));
      kept = 0;
      for (int i = 0; i < win_count; i++) begin
        src = (win_head + i) % WINDOW_DEPTH;
        if (!is_aged(now, win_time[src])) begin
          dst = (win_head + kept) % WINDOW_DEPTH;
          win_smp[dst] = win_smp[src];
          win_time[dst] = win_time[src];
          kept++;
        end
      end
      win_count = kept;
    end
    tmax = c_thr[0] && (r.value > c_max);
    tmin = c_thr[1] && (r.value < c_min);
    if (tmax || tmin) begin
      r.healthy = 1'b0;
      if (last_report == 0 || c_rep == 0 ||
          (now >= last_report && (now - last_report) > {16'd0, c_rep})) begin
        last_report = now;
        alarm_on = 1'b1;
        r.report = 1'b1;
        r.kind = tmin ? EV_BELOW : EV_ABOVE;
      end
    end else if (alarm_on) begin
      alarm_on = 1'b0;
      r.report = 1'b1;
      r.kind = EV_NORMAL;
    end
    return r;
  endfunction

  // request acceptance, result checking
  always @(posedge clk) begin
    alarm_res_t e;
    logic signed [15:0] got_val;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_q.push_back(alarm_predict(in_tdata[31:0], in_tdata[47:32]));
        n_samples++;
      end
      if (out_tvalid && out_tready) begin
        got_val = out_tdata[16:1];
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: tdata %h tuser %h", out_tdata, out_tuser);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[0] !== e.report) begin
            $error("report: expected %0d actual %0d", e.report, out_tdata[0]); errors++;
          end
          if (out_tuser !== e.kind) begin
            $error("event_kind: expected %0d actual %0d", e.kind, out_tuser); errors++;
          end
          if (got_val !== e.value) begin
            $error("checked_value: expected %0d actual %0d", e.value, got_val); errors++;
          end
          if (out_tdata[17] !== e.healthy) begin
            $error("healthy: expected %0d actual %0d", e.healthy, out_tdata[17]); errors++;
          end
          if (out_tdata[18] !== e.ovf) begin
            $error("window_overflow: expected %0d actual %0d", e.ovf, out_tdata[18]); errors++;
          end
          if (out_tdata[23:19] !== 5'd0) begin
            $error("tdata pad: expected 0 actual %0d", out_tdata[23:19]); errors++;
          end
          if (e.report) n_reports++;
          if (e.ovf) n_overflows++;
        end
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    sample_req_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_q.size() == 0 || $urandom_range(0, 99) < send_pct) begin
        in_tvalid <= 1'b0;
      end else begin
        it = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {it.smp, it.now};
      end
    end
  end

  // result receiver, with one long hold-off when armed
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (pressure_armed && !hold_done && in_tvalid) begin
      out_tready <= 1'b0;
      hold_cnt <= 600;
      hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_ENABLE:    c_en = d[0];
      REG_AGG_MODE:  c_agg = d[1:0];
      REG_THR_MODE:  c_thr = d[1:0];
      REG_MAX_LIMIT: c_max = d;
      REG_MIN_LIMIT: c_min = d;
      REG_WINDOW:    c_win = d;
      REG_REPEAT:    c_rep = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(logic [31:0] now, logic signed [15:0] s);
    pending_q.push_back('{now, s});
  endtask

  // drain all requests and results, then let the block go idle
  task automatic settle();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_all(logic en, logic [1:0] agg, logic [1:0] thr, logic [15:0] mxl,
                         logic [15:0] mnl, logic [15:0] win, logic [15:0] rep);
    write_reg(REG_ENABLE, {15'd0, en});
    write_reg(REG_AGG_MODE, {14'd0, agg});
    write_reg(REG_THR_MODE, {14'd0, thr});
    write_reg(REG_MAX_LIMIT, mxl);
    write_reg(REG_MIN_LIMIT, mnl);
    write_reg(REG_WINDOW, win);
    write_reg(REG_REPEAT, rep);
  endtask

  // mostly steady time with small steps, some backward jumps and arbitrary times
  task automatic gen_samples(int n);
    int r;
    logic signed [15:0] s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 17) t_cur = t_cur + $urandom_range(0, 3);
      else if (r < 19) t_cur = t_cur - $urandom_range(0, 10);
      else t_cur = $urandom;
      case ($urandom_range(0, 3))
        0: s = 16'($urandom);
        1: s = c_max + $signed(16'($urandom_range(0, 40))) - 16'sd20;
        2: s = c_min + $signed(16'($urandom_range(0, 40))) - 16'sd20;
        default: s = $signed(16'($urandom_range(0, 400))) - 16'sd200;
      endcase
      push_sample(t_cur, s);
    end
  endtask

  initial begin
    logic [15:0] win, rep, mxl, mnl;
    errors = 0; n_samples = 0; n_reports = 0; n_overflows = 0;
    send_pct = 0; recv_pct = 0;
    pressure_armed = 1'b0;
    c_en = 0; c_agg = 0; c_thr = 0; c_max = 0; c_min = 0; c_win = 0; c_rep = 0;
    win_head = 0; win_count = 0; alarm_on = 1'b0; last_report = 0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // disabled at reset: results are all idle
    push_sample(32'd5, 16'sd32767);
    push_sample(32'hFFFF_FFFF, -16'sd32768);
    settle();

    // directed: time zero reports, repeat gating, aging, backward time, extremes
    set_all(1'b1, AGG_AVG, 2'd3, 16'd100, 16'hFF9C, 16'd5, 16'd3);
    push_sample(32'd0, 16'sd0);
    push_sample(32'd0, 16'sd200);
    push_sample(32'd1, 16'sd200);
    push_sample(32'd2, -16'sd32768);
    push_sample(32'd10, 16'sd32767);
    push_sample(32'd11, -16'sd32768);
    push_sample(32'd5, 16'sd0);
    push_sample(32'd30, 16'sd0);
    push_sample(32'hFFFF_FFFF, 16'sd32767);
    push_sample(32'd40, 16'sd50);
    settle();
    // min limit above max limit: both cross
    write_reg(REG_MAX_LIMIT, 16'hFF00);
    write_reg(REG_MIN_LIMIT, 16'd256);
    write_reg(REG_AGG_MODE, {14'd0, AGG_MAX});
    push_sample(32'd50, 16'sd0);
    push_sample(32'd60, 16'sd1);
    settle();
    write_reg(REG_AGG_MODE, {14'd0, AGG_MIN});
    write_reg(REG_REPEAT, 16'd0);
    push_sample(32'd70, 16'sd7);
    push_sample(32'd80, -16'sd9);
    settle();
    write_reg(REG_AGG_MODE, 16'd3);
    write_reg(REG_THR_MODE, 16'd0);
    push_sample(32'd90, 16'sd3);
    push_sample(32'd100, 16'sd5);
    settle();

    // random phases; the first fills the window past its depth
    t_cur = 32'd1000;
    for (int p = 0; p < 8; p++) begin
      case (p % 3)
        0: begin send_pct = 34; recv_pct = 86; end
        1: begin send_pct = 86; recv_pct = 34; end
        default: begin send_pct = 0; recv_pct = 0; end
      endcase
      pressure_armed = (p == 2);
      win = (p == 0) ? 16'd65535 : (p == 5) ? 16'd0 : 16'($urandom_range(1, 30));
      rep = (p == 3) ? 16'd65535 : 16'($urandom_range(0, 10));
      mxl = (p == 6) ? 16'h7FFF : 16'($urandom_range(0, 600));
      mnl = (p == 6) ? 16'h8000 : -16'($urandom_range(0, 600));
      if (p == 7) begin
        mxl = 16'h8000;
        mnl = 16'h7FFF;
      end
      set_all(p != 4, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), mxl, mnl, win, rep);
      gen_samples(175);
      settle();
    end

    $display("covered %0d samples over directed and 8 random settings", n_samples);
    $display("saw %0d reports and %0d window overwrites", n_reports, n_overflows);
    if (errors == 0) begin
      $display("tb_windowed_threshold_alarm: clean");
    end else begin
      $display("tb_windowed_threshold_alarm: errors");
    end
    $finish;
  end

endmodule
